FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property, checked on every rising edge.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/rgb_scl_pkg.sv
// ---------------------------------------------------------------------------
// rgb_scl_pkg
// Constants and register index codes for the RGB888 to RGB565 scaler.
// ---------------------------------------------------------------------------
package rgb_scl_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_TINT_ENABLE  = 3'd0,
      CSR_TINT_COLOR   = 3'd1,
      CSR_IMAGE_WIDTH  = 3'd2,
      CSR_IMAGE_HEIGHT = 3'd3,
      CSR_SCALE_FACTOR = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int             SCALE_W   = 4;
   localparam int             COPY_W    = 3;
   localparam logic [SCALE_W-1:0] MAX_SCALE = 4'd8;

   // Rounding converter coefficients
   localparam logic [15:0] RB_MUL = 16'd249;
   localparam logic [15:0] RB_ADD = 16'd1014;
   localparam logic [15:0] G_MUL  = 16'd253;
   localparam logic [15:0] G_ADD  = 16'd505;

endpackage

FILE: rtl/rgb888_to_rgb565_scaler.sv
// ---------------------------------------------------------------------------
// rgb888_to_rgb565_scaler
// RGB888 to RGB565 pixel converter with optional tint and integer upscale.
// ---------------------------------------------------------------------------
// Each accepted pixel is tinted (if enabled), rounded to RGB565 and placed in
// the result register; that word is then emitted S times, one copy per cycle
// while rsp_stall is low, with run_last on the final copy, S being the
// effective scale (1 to 8). A new pixel is taken in the same cycle as the final
// copy of the previous one leaves, so the block cannot take a new pixel before
// every copy of the previous one has left. At the end of a row, replay_row on
// the last copy asks the source to resend the row until all S passes are
// drawn; image_done marks the last copy of the image, after which the counters
// start a new image. Configuration writes are taken at any time and do not
// touch the counters.
module rgb888_to_rgb565_scaler (
   input  logic                                  clock,
   input  logic                                  reset,
   // input pixel channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_red_in,
   input  logic [7:0]                            req_green_in,
   input  logic [7:0]                            req_blue_in,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [15:0]                           rsp_pixel_565,
   output logic                                  rsp_run_last,
   output logic                                  rsp_replay_row,
   output logic                                  rsp_image_done,
   // configuration port
   input  logic                                  csr_we,
   input  logic [rgb_scl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rgb_scl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic                              tint_enable_ff;
   logic [15:0]                       tint_color_ff;
   logic [15:0]                       image_width_ff;
   logic [15:0]                       image_height_ff;
   logic [rgb_scl_pkg::SCALE_W-1:0]   scale_factor_ff;

   // position counters
   logic [15:0]                       column_ff, column_in;
   logic [15:0]                       row_ff, row_in;
   logic [rgb_scl_pkg::COPY_W-1:0]    pass_ff, pass_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [15:0]                       pixel_ff, pixel_in;
   logic                              replay_ff, replay_in;
   logic                              done_ff, done_in;
   logic [rgb_scl_pkg::COPY_W-1:0]    left_ff, left_in;

   logic                              last_copy;
   logic                              req_accept;
   logic [rgb_scl_pkg::SCALE_W-1:0]   scale_eff;
   logic [15:0]                       width_m1;
   logic [15:0]                       height_m1;
   logic [rgb_scl_pkg::SCALE_W-1:0]   pass_next;
   logic [7:0]                        tint_r, tint_g, tint_b;
   logic [8:0]                        sum_r, sum_g, sum_b;
   logic [7:0]                        mix_r, mix_g, mix_b;
   logic [15:0]                       prod_r, prod_g, prod_b;
   logic [15:0]                       color;
   logic                              replay_new, done_new;

   assign last_copy  = (left_ff == '0);
   // take a new word only when the result register is empty or empties this cycle
   assign req_stall  = rsp_valid_ff && !(last_copy && !rsp_stall);
   assign req_accept = req_valid && !req_stall;

   // ---- pixel datapath ----
   always_comb begin
      tint_r = {tint_color_ff[15:11], 3'b000};
      tint_g = {tint_color_ff[10:5], 2'b00};
      tint_b = {tint_color_ff[4:0], 3'b000};
      sum_r  = {1'b0, req_red_in}   + {1'b0, tint_r};
      sum_g  = {1'b0, req_green_in} + {1'b0, tint_g};
      sum_b  = {1'b0, req_blue_in}  + {1'b0, tint_b};
      mix_r  = tint_enable_ff ? sum_r[8:1] : req_red_in;
      mix_g  = tint_enable_ff ? sum_g[8:1] : req_green_in;
      mix_b  = tint_enable_ff ? sum_b[8:1] : req_blue_in;
      prod_r = {8'd0, mix_r} * rgb_scl_pkg::RB_MUL + rgb_scl_pkg::RB_ADD;
      prod_g = {8'd0, mix_g} * rgb_scl_pkg::G_MUL  + rgb_scl_pkg::G_ADD;
      prod_b = {8'd0, mix_b} * rgb_scl_pkg::RB_MUL + rgb_scl_pkg::RB_ADD;
      color  = {prod_r[15:11], prod_g[15:10], prod_b[15:11]};
   end

   // ---- position tracking ----
   always_comb begin
      if (scale_factor_ff == '0) begin
         scale_eff = rgb_scl_pkg::SCALE_W'(1);
      end else if (scale_factor_ff > rgb_scl_pkg::MAX_SCALE) begin
         scale_eff = rgb_scl_pkg::MAX_SCALE;
      end else begin
         scale_eff = scale_factor_ff;
      end
      width_m1   = (image_width_ff  == '0) ? 16'd0 : image_width_ff  - 16'd1;
      height_m1  = (image_height_ff == '0) ? 16'd0 : image_height_ff - 16'd1;
      pass_next  = {1'b0, pass_ff} + rgb_scl_pkg::SCALE_W'(1);
      column_in  = column_ff;
      row_in     = row_ff;
      pass_in    = pass_ff;
      replay_new = 1'b0;
      done_new   = 1'b0;
      if (column_ff >= width_m1) begin
         column_in = '0;
         if (pass_next >= scale_eff) begin
            pass_in = '0;
            if (row_ff >= height_m1) begin
               row_in   = '0;
               done_new = 1'b1;
            end else begin
               row_in = row_ff + 16'd1;
            end
         end else begin
            pass_in    = pass_next[rgb_scl_pkg::COPY_W-1:0];
            replay_new = 1'b1;
         end
      end else begin
         column_in = column_ff + 16'd1;
      end
   end

   // ---- result register next state ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pixel_in     = pixel_ff;
      replay_in    = replay_ff;
      done_in      = done_ff;
      left_in      = left_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         pixel_in     = color;
         replay_in    = replay_new;
         done_in      = done_new;
         left_in      = rgb_scl_pkg::COPY_W'(scale_eff - rgb_scl_pkg::SCALE_W'(1));
      end else if (rsp_valid_ff && !rsp_stall) begin
         if (last_copy) begin
            rsp_valid_in = 1'b0;
         end else begin
            left_in = left_ff - rgb_scl_pkg::COPY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            column_ff <= column_in;
            row_ff    <= row_in;
            pass_ff   <= pass_in;
         end
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      pixel_ff  <= pixel_in;
      replay_ff <= replay_in;
      done_ff   <= done_in;
      left_ff   <= left_in;
   end

   // ---- configuration registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         tint_enable_ff  <= 1'b0;
         tint_color_ff   <= '0;
         image_width_ff  <= 16'd1;
         image_height_ff <= 16'd1;
         scale_factor_ff <= rgb_scl_pkg::SCALE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            rgb_scl_pkg::CSR_TINT_ENABLE:  tint_enable_ff  <= csr_wdata[0];
            rgb_scl_pkg::CSR_TINT_COLOR:   tint_color_ff   <= csr_wdata;
            rgb_scl_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            rgb_scl_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            rgb_scl_pkg::CSR_SCALE_FACTOR: begin
               scale_factor_ff <= csr_wdata[rgb_scl_pkg::SCALE_W-1:0];
            end
            default: begin
               // drop writes outside the register list
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_565  = pixel_ff;
   assign rsp_run_last   = last_copy;
   assign rsp_replay_row = replay_ff && last_copy;
   assign rsp_image_done = done_ff && last_copy;

endmodule

FILE: rtl/rgb_scl_checker.sv
// ---------------------------------------------------------------------------
// rgb_scl_checker
// Port-level assertions for the RGB888 to RGB565 scaler, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_scl_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [15:0]                           rsp_pixel_565,
   input  logic                                  rsp_run_last,
   input  logic                                  rsp_replay_row,
   input  logic                                  rsp_image_done
);

   // stalled result word holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_565),
      "stalled result word changed")

   // every copy but the last is followed by another copy of the same colour
   `ASSERT_CLK_RST(a_copy_run, clock, reset,
      rsp_valid && !rsp_stall && !rsp_run_last |=> rsp_valid && $stable(rsp_pixel_565),
      "copy run broken before run_last")

   // an accepted pixel shows up in the result register next cycle
   `ASSERT_CLK_RST(a_accept_fill, clock, reset,
      req_valid && !req_stall |=> rsp_valid,
      "accepted pixel produced no result")

   // row and image flags sit only on the last copy of a valid word, never together
   `ASSERT_CLK_RST(a_done_last, clock, reset,
      !rsp_valid || !rsp_image_done || rsp_run_last,
      "image_done off the last copy")

   `ASSERT_CLK_RST(a_replay_last, clock, reset,
      !rsp_valid || !rsp_replay_row || (rsp_run_last && !rsp_image_done),
      "replay_row off the last copy or with image_done")

endmodule

bind rgb888_to_rgb565_scaler rgb_scl_checker u_rgb_scl_checker (.*);

FILE: tb/pixel_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_scoreboard_pkg
// Scoreboard for the RGB888 to RGB565 scaler. It mirrors the registers and
// the column, row and pass counters, predicts the copies that each accepted
// pixel produces and checks every result word against the oldest prediction.
// ---------------------------------------------------------------------------
package pixel_scoreboard_pkg;

   class pixel_scoreboard;
      typedef struct {
         logic [15:0] pixel;
         logic        run_last;
         logic        replay_row;
         logic        image_done;
      } pixel_copy_type;

      pixel_copy_type expected_copies[$];

      // shadow registers
      bit              tint_on;
      bit [15:0]       tint_rgb;
      bit [15:0]       width_reg;
      bit [15:0]       height_reg;
      bit [rgb_scl_pkg::SCALE_W-1:0] scale_reg;

      // position in the image
      int unsigned column_count;
      int unsigned row_count;
      int unsigned pass_count;

      int errors;

      function new();
         tint_on      = 1'b0;
         tint_rgb     = 16'h0000;
         width_reg    = 16'd1;
         height_reg   = 16'd1;
         scale_reg    = 4'd1;
         column_count = 0;
         row_count    = 0;
         pass_count   = 0;
         errors       = 0;
      endfunction

      function void write_reg(input logic [rgb_scl_pkg::CSR_INDEX_W-1:0] idx,
                              input logic [rgb_scl_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rgb_scl_pkg::CSR_TINT_ENABLE:  tint_on    = data[0];
            rgb_scl_pkg::CSR_TINT_COLOR:   tint_rgb   = data;
            rgb_scl_pkg::CSR_IMAGE_WIDTH:  width_reg  = data;
            rgb_scl_pkg::CSR_IMAGE_HEIGHT: height_reg = data;
            rgb_scl_pkg::CSR_SCALE_FACTOR: scale_reg  = data[rgb_scl_pkg::SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_copies.size();
      endfunction

      function int unsigned blend(input int unsigned chan, input int unsigned tint);
         return tint_on ? (chan + tint) >> 1 : chan;
      endfunction

      function void note_pixel(input logic [7:0] red, input logic [7:0] green,
                               input logic [7:0] blue);
         int unsigned eff_scale, eff_w, eff_h;
         int unsigned r, g, b, r5, g6, b5;
         bit [15:0]   color;
         bit          replay, done;
         pixel_copy_type c;

         eff_scale = (scale_reg == 0) ? 1 : scale_reg;
         if (eff_scale > rgb_scl_pkg::MAX_SCALE)
            eff_scale = rgb_scl_pkg::MAX_SCALE;
         eff_w = (width_reg == 0) ? 1 : width_reg;
         eff_h = (height_reg == 0) ? 1 : height_reg;

         // expand the 565 tint back to 8 bits per channel
         r = blend(red,   int'(tint_rgb[15:11]) * 8);
         g = blend(green, int'(tint_rgb[10:5]) * 4);
         b = blend(blue,  int'(tint_rgb[4:0]) * 8);

         r5 = ((r * rgb_scl_pkg::RB_MUL + rgb_scl_pkg::RB_ADD) >> 11) & 'h1F;
         g6 = ((g * rgb_scl_pkg::G_MUL + rgb_scl_pkg::G_ADD) >> 10) & 'h3F;
         b5 = ((b * rgb_scl_pkg::RB_MUL + rgb_scl_pkg::RB_ADD) >> 11) & 'h1F;
         color = {r5[4:0], g6[5:0], b5[4:0]};

         replay = 1'b0;
         done   = 1'b0;
         // counters past the configured size end the row, pass or image
         if (column_count >= eff_w - 1) begin
            column_count = 0;
            pass_count++;
            if (pass_count >= eff_scale) begin
               pass_count = 0;
               if (row_count >= eff_h - 1) begin
                  row_count = 0;
                  done      = 1'b1;
               end else begin
                  row_count = (row_count + 1) & 'hFFFF;
               end
            end else begin
               replay = 1'b1;
            end
         end else begin
            column_count = (column_count + 1) & 'hFFFF;
         end

         for (int k = 0; k < eff_scale; k++) begin
            c.pixel      = color;
            c.run_last   = (k + 1 == eff_scale);
            c.replay_row = c.run_last & replay;
            c.image_done = c.run_last & done;
            expected_copies.push_back(c);
         end
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 100)
            $display("%0t ERROR %s", $time, what);
      endtask

      task check_copy(input logic [15:0] pixel, input logic run_last,
                      input logic replay_row, input logic image_done);
         pixel_copy_type want;
         if (expected_copies.size() == 0) begin
            report($sformatf("word with no pixel pending: pixel_565=%h", pixel));
            return;
         end
         want = expected_copies.pop_front();
         if (pixel !== want.pixel)
            report($sformatf("pixel_565 %h, predicted %h", pixel, want.pixel));
         if (run_last !== want.run_last)
            report($sformatf("run_last %b, predicted %b", run_last, want.run_last));
         if (replay_row !== want.replay_row)
            report($sformatf("replay_row %b, predicted %b", replay_row, want.replay_row));
         if (image_done !== want.image_done)
            report($sformatf("image_done %b, predicted %b", image_done, want.image_done));
      endtask
   endclass

endpackage

FILE: tb/rgb888_to_rgb565_scaler_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb888_to_rgb565_scaler_tb
// Self-checking bench for the RGB888 to RGB565 scaler. A short directed set
// covers channel extremes, tint, scale and size corner values and counters
// left past a shrunk image; random phases then stream mostly whole images
// with random settings while both channels idle at random, including one
// long receiver hold-off that backs the block up.
// ---------------------------------------------------------------------------
module rgb888_to_rgb565_scaler_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 180;
   localparam int LONG_HOLD    = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid    = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_red_in   = 8'h00;
   logic [7:0]                          req_green_in = 8'h00;
   logic [7:0]                          req_blue_in  = 8'h00;
   logic                                rsp_valid;
   logic                                rsp_stall    = 1'b0;
   logic [15:0]                         rsp_pixel_565;
   logic                                rsp_run_last;
   logic                                rsp_replay_row;
   logic                                rsp_image_done;
   logic                                csr_we       = 1'b0;
   logic [rgb_scl_pkg::CSR_INDEX_W-1:0] csr_index    = '0;
   logic [rgb_scl_pkg::CSR_DATA_W-1:0]  csr_wdata    = '0;

   pixel_scoreboard_pkg::pixel_scoreboard board = new();

   int cycle_count   = 0;
   int burst_left    = 0;
   bit gaps_on       = 1'b1;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int stall_mode    = 0;
   int mode_left     = 0;

   rgb888_to_rgb565_scaler DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_565  (rsp_pixel_565),
      .rsp_run_last   (rsp_run_last),
      .rsp_replay_row (rsp_replay_row),
      .rsp_image_done (rsp_image_done),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall pattern; a pending hold request overrides it
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= LONG_HOLD;
         rsp_stall   <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 60);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_copy(rsp_pixel_565, rsp_run_last, rsp_replay_row, rsp_image_done);

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic write_csr(input logic [rgb_scl_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rgb_scl_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (req_stall);
      board.note_pixel(r, g, b);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan());
   endtask

   // hold until every predicted word has left, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int random_sent;
      int w, h, s, eff_w, eff_h, eff_s, n;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one pixel per image, one copy each
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hAA, 8'h55, 8'hA5);
      drain();

      // unused register indexes must be ignored
      for (int i = int'(rgb_scl_pkg::CSR_SCALE_FACTOR) + 1; i < 2 ** rgb_scl_pkg::CSR_INDEX_W;
           i++)
         write_csr(i[rgb_scl_pkg::CSR_INDEX_W-1:0], 16'($urandom_range(0, 65535)));

      // full tint, zero scale and zero sizes fall back to 1
      write_csr(rgb_scl_pkg::CSR_TINT_ENABLE, 16'h0001);
      write_csr(rgb_scl_pkg::CSR_TINT_COLOR, 16'hFFFF);
      write_csr(rgb_scl_pkg::CSR_IMAGE_WIDTH, 16'h0000);
      write_csr(rgb_scl_pkg::CSR_IMAGE_HEIGHT, 16'h0000);
      write_csr(rgb_scl_pkg::CSR_SCALE_FACTOR, 16'h0000);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h80, 8'h7F, 8'h01);
      drain();

      // scale above the maximum saturates
      write_csr(rgb_scl_pkg::CSR_TINT_COLOR, 16'hF81F);
      write_csr(rgb_scl_pkg::CSR_SCALE_FACTOR, 16'h0009);
      write_csr(rgb_scl_pkg::CSR_IMAGE_WIDTH, 16'h0002);
      write_csr(rgb_scl_pkg::CSR_IMAGE_HEIGHT, 16'h0001);
      send_random(4);
      drain();

      // upper data bits ignored; stop mid-image
      write_csr(rgb_scl_pkg::CSR_TINT_ENABLE, 16'hFFFE);
      write_csr(rgb_scl_pkg::CSR_SCALE_FACTOR, 16'hFFF2);
      write_csr(rgb_scl_pkg::CSR_IMAGE_WIDTH, 16'h0003);
      write_csr(rgb_scl_pkg::CSR_IMAGE_HEIGHT, 16'h0002);
      send_random(4);
      drain();

      // shrink the image under the counters
      write_csr(rgb_scl_pkg::CSR_SCALE_FACTOR, 16'h0001);
      write_csr(rgb_scl_pkg::CSR_IMAGE_WIDTH, 16'h0001);
      write_csr(rgb_scl_pkg::CSR_IMAGE_HEIGHT, 16'h0001);
      send_random(3);
      drain();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
         s = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 15);
         write_csr(rgb_scl_pkg::CSR_TINT_ENABLE, 16'($urandom_range(0, 65535)));
         write_csr(rgb_scl_pkg::CSR_TINT_COLOR, 16'($urandom_range(0, 65535)));
         write_csr(rgb_scl_pkg::CSR_IMAGE_WIDTH, 16'(w));
         write_csr(rgb_scl_pkg::CSR_IMAGE_HEIGHT, 16'(h));
         write_csr(rgb_scl_pkg::CSR_SCALE_FACTOR, {12'($urandom_range(0, 4095)), 4'(s)});
         eff_w = (w == 0) ? 1 : w;
         eff_h = (h == 0) ? 1 : h;
         eff_s = (s == 0) ? 1 : ((s > 8) ? 8 : s);
         // mostly whole images; oversized ones become partial runs
         n = eff_w * eff_h * eff_s;
         if (n > 48 || $urandom_range(0, 5) == 0)
            n = $urandom_range(8, 48);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (random_sent == 0)
            hold_requests++;
         send_random(n);
         random_sent += n;
         drain();
      end

      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
